// File: sv/tae_pkg.sv
// Shared constants, types and opcodes for the integer-subset executor.
package tae_pkg;

	localparam int STACK_BYTES = 64;
	localparam int NUM_REGS    = 32;
	localparam int REG_AW      = $clog2(NUM_REGS);
	localparam int STACK_ROWS  = STACK_BYTES / 4;
	localparam int ROW_AW      = $clog2(STACK_ROWS);
	localparam int SADDR_W     = ROW_AW + 2;

	localparam logic [7:0]  LIMIT_RESET = 8'd8;
	localparam logic [63:0] STACK_TOP   = 64'(STACK_BYTES);
	localparam logic [63:0] ADDR_MAX    = 64'(STACK_BYTES - 4);

	localparam logic REQ_START = 1'b0;
	localparam logic REQ_EXEC  = 1'b1;

	localparam logic [15:0] OP_LDR32  = 16'hB940;
	localparam logic [15:0] OP_STR32  = 16'hB900;
	localparam logic [15:0] OP_SUBI   = 16'hD100;
	localparam logic [15:0] OP_ADDR   = 16'h0B00;
	localparam logic [15:0] OP_ADDI   = 16'h9100;
	localparam logic [15:0] OP_RET    = 16'hD65F;

	typedef enum logic [2:0] {
		ST_RUN     = 3'd0,
		ST_RET     = 3'd1,
		ST_BADOP   = 3'd2,
		ST_BADADDR = 3'd3,
		ST_LIMIT   = 3'd4,
		ST_IDLE    = 3'd5
	} status_t;

	typedef struct packed {
		logic              en;
		logic [REG_AW-1:0] addr;
		logic [63:0]       data;
	} rf_wr_t;

	typedef struct packed {
		logic               we;
		logic [SADDR_W-1:0] addr;
		logic [31:0]        data;
	} stk_req_t;

endpackage

// File: sv/tae_regfile.sv
// 64-bit register file: three indexed read ports, r0 port, one write port, start load.
module tae_regfile (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic signed [63:0]          arg_first,
	input  logic signed [63:0]          arg_second,
	input  tae_pkg::rf_wr_t             wr,
	input  logic [tae_pkg::REG_AW-1:0]  rn_addr,
	input  logic [tae_pkg::REG_AW-1:0]  rm_addr,
	input  logic [tae_pkg::REG_AW-1:0]  rd_addr,
	output logic [63:0]                 rn_data,
	output logic [63:0]                 rm_data,
	output logic [63:0]                 rd_data,
	output logic [63:0]                 r0_data
);

	logic [63:0] regs_q [tae_pkg::NUM_REGS];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tae_pkg::NUM_REGS; i++) begin
				regs_q[i] <= '0;
			end
		end else if (start) begin
			regs_q[0]                     <= arg_second;
			regs_q[1]                     <= arg_first;
			regs_q[tae_pkg::NUM_REGS - 1] <= tae_pkg::STACK_TOP;
		end else if (wr.en) begin
			regs_q[wr.addr] <= wr.data;
		end
	end

	assign rn_data = regs_q[rn_addr];
	assign rm_data = regs_q[rm_addr];
	assign rd_data = regs_q[rd_addr];
	assign r0_data = regs_q[0];

endmodule

// File: sv/tae_stack.sv
// Byte-addressed stack split into four byte lanes for unaligned 32-bit access.
module tae_stack (
	input  logic                 clk,
	input  logic                 arst_n,
	input  tae_pkg::stk_req_t    req,
	output logic [31:0]          rd_word
);

	logic [7:0] bank_q [4][tae_pkg::STACK_ROWS];

	logic [tae_pkg::ROW_AW-1:0] row;
	logic [1:0]                 lo;
	logic [tae_pkg::ROW_AW-1:0] bank_row [4];
	logic [7:0]                 bank_rd  [4];
	logic [7:0]                 bank_wd  [4];

	assign row = req.addr[tae_pkg::SADDR_W-1:2];
	assign lo  = req.addr[1:0];

	// lanes below the start lane wrap into the next row; an in-range access never
	// leaves the array
	always_comb begin
		for (int b = 0; b < 4; b++) begin
			bank_row[b] = (2'(b) >= lo) ? row : row + 1'b1;
			bank_rd[b]  = bank_q[b][bank_row[b]];
			bank_wd[b]  = req.data[8 * (2'(2'(b) - lo)) +: 8];
		end
		for (int j = 0; j < 4; j++) begin
			rd_word[8 * j +: 8] = bank_rd[2'(lo + 2'(j))];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < 4; b++) begin
				for (int r = 0; r < tae_pkg::STACK_ROWS; r++) begin
					bank_q[b][r] <= '0;
				end
			end
		end else if (req.we) begin
			for (int b = 0; b < 4; b++) begin
				bank_q[b][bank_row[b]] <= bank_wd[b];
			end
		end
	end

endmodule

// File: sv/tiny_a64_subset_executor.sv
// Executes one request per cycle unless out_stall holds a result: start or
// decode-and-execute of one instruction word. The block takes one transaction
// every cycle while the output is not stalled; the request is held in an input
// register and its result is loaded into the result register when the output
// advances. Decode, register read, the 64-bit address or arithmetic add, the
// stack access and the write back all happen combinationally between the two
// registers, so a following instruction sees the effect of the previous one
// with no wait. The register file and the 64-byte stack are reset-cleared flops,
// so there is no clearing pass. The user writes insn_limit via cfg_we/cfg_wdata
// only while no transaction is in flight; the block does not enforce this.
module tiny_a64_subset_executor (
	input  logic               clk,
	input  logic               arst_n,

	input  logic               cfg_we,
	input  logic [7:0]         cfg_wdata,

	input  logic               in_valid,
	output logic               in_stall,
	input  logic               req_type,
	input  logic [31:0]        insn_word,
	input  logic signed [63:0] arg_first,
	input  logic signed [63:0] arg_second,

	output logic               out_valid,
	input  logic               out_stall,
	output logic [2:0]         status,
	output logic signed [63:0] ret_value
);

	// input stage
	logic               valid_s1;
	logic               req_type_s1;
	logic [31:0]        insn_s1;
	logic signed [63:0] arg_first_s1;
	logic signed [63:0] arg_second_s1;

	// result stage
	logic               out_valid_q;
	tae_pkg::status_t   status_q;
	logic [63:0]        ret_value_q;

	// architectural state
	logic [7:0] limit_q;
	logic [7:0] insn_count_q;
	logic       running_q;

	logic advance;
	logic fire;

	logic [15:0]                opcode;
	logic [tae_pkg::REG_AW-1:0] rd;
	logic [tae_pkg::REG_AW-1:0] rn;
	logic [tae_pkg::REG_AW-1:0] rm;
	logic [11:0]                imm;
	logic [63:0]                rn_val;
	logic [63:0]                rm_val;
	logic [63:0]                rd_val;
	logic [63:0]                r0_val;
	logic [63:0]                addr_sum;
	logic                       addr_ok;
	logic [31:0]                load_word;

	tae_pkg::rf_wr_t   rf_wr;
	tae_pkg::stk_req_t stk_req;
	tae_pkg::status_t  status_d;
	logic [63:0]       value_d;
	logic              counted;
	logic [7:0]        count_inc;
	logic [7:0]        count_d;
	logic              running_d;
	logic              start;

	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign fire     = valid_s1 && advance;
	assign start    = fire && (req_type_s1 == tae_pkg::REQ_START);

	assign opcode = insn_s1[31:16];
	assign rd     = insn_s1[4:0];
	assign rn     = insn_s1[9:5];
	assign rm     = insn_s1[20:16];
	assign imm    = insn_s1[21:10];

	assign addr_sum  = rn_val + 64'({imm, 2'b00});
	assign addr_ok   = addr_sum <= tae_pkg::ADDR_MAX;
	assign count_inc = insn_count_q + 8'd1;

	tae_regfile u_regfile (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.arg_first  (arg_first_s1),
		.arg_second (arg_second_s1),
		.wr         (rf_wr),
		.rn_addr    (rn),
		.rm_addr    (rm),
		.rd_addr    (rd),
		.rn_data    (rn_val),
		.rm_data    (rm_val),
		.rd_data    (rd_val),
		.r0_data    (r0_val)
	);

	tae_stack u_stack (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (stk_req),
		.rd_word (load_word)
	);

	always_comb begin
		status_d     = tae_pkg::ST_RUN;
		value_d      = '0;
		counted      = 1'b0;
		count_d      = insn_count_q;
		running_d    = running_q;
		rf_wr.en     = 1'b0;
		rf_wr.addr   = rd;
		rf_wr.data   = '0;
		stk_req.we   = 1'b0;
		stk_req.addr = addr_sum[tae_pkg::SADDR_W-1:0];
		stk_req.data = rd_val[31:0];

		if (req_type_s1 == tae_pkg::REQ_START) begin
			count_d   = '0;
			running_d = 1'b1;
		end else if (!running_q) begin
			status_d = tae_pkg::ST_IDLE;
		end else begin
			case (opcode)
				tae_pkg::OP_LDR32: begin
					if (addr_ok) begin
						rf_wr.en   = 1'b1;
						rf_wr.data = {{32{load_word[31]}}, load_word};
						counted    = 1'b1;
					end else begin
						status_d = tae_pkg::ST_BADADDR;
					end
				end
				tae_pkg::OP_STR32: begin
					if (addr_ok) begin
						stk_req.we = 1'b1;
						counted    = 1'b1;
					end else begin
						status_d = tae_pkg::ST_BADADDR;
					end
				end
				tae_pkg::OP_SUBI: begin
					rf_wr.en   = 1'b1;
					rf_wr.data = rn_val - 64'(imm);
					counted    = 1'b1;
				end
				tae_pkg::OP_ADDR: begin
					rf_wr.en   = 1'b1;
					rf_wr.data = rn_val + rm_val;
					counted    = 1'b1;
				end
				tae_pkg::OP_ADDI: begin
					rf_wr.en   = 1'b1;
					rf_wr.data = rn_val + 64'(imm);
					counted    = 1'b1;
				end
				tae_pkg::OP_RET: begin
					status_d = tae_pkg::ST_RET;
					value_d  = r0_val;
				end
				default: begin
					status_d = tae_pkg::ST_BADOP;
				end
			endcase

			if (counted) begin
				count_d = count_inc;
				// a limit of zero also stops after the first instruction
				if (count_inc >= limit_q) begin
					status_d = tae_pkg::ST_LIMIT;
				end
			end
			if (status_d != tae_pkg::ST_RUN) begin
				running_d = 1'b0;
			end
		end

		rf_wr.en   = rf_wr.en && fire;
		stk_req.we = stk_req.we && fire;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			req_type_s1   <= req_type;
			insn_s1       <= insn_word;
			arg_first_s1  <= arg_first;
			arg_second_s1 <= arg_second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			limit_q      <= tae_pkg::LIMIT_RESET;
			insn_count_q <= '0;
			running_q    <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q <= valid_s1;
			end
			if (cfg_we) begin
				limit_q <= cfg_wdata;
			end
			if (fire) begin
				insn_count_q <= count_d;
				running_q    <= running_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			status_q    <= status_d;
			ret_value_q <= value_d;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign ret_value = ret_value_q;

endmodule

// File: verif/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for tiny_a64_subset_executor: directed table, then random programs.
module tb_top;

	localparam int          MAX_CYCLES = 400000;
	localparam logic [63:0] POS_MAX    = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] NEG_MIN    = 64'h8000_0000_0000_0000;
	localparam logic [63:0] ALL_ONES   = 64'hFFFF_FFFF_FFFF_FFFF;
	localparam int          SP         = 31;

	typedef struct packed {
		tae_pkg::status_t st;
		logic [63:0]      val;
	} exec_outcome_t;

	typedef struct {
		logic             rt;
		logic [31:0]      w;
		logic [63:0]      a1;
		logic [63:0]      a2;
		bit               pin;
		tae_pkg::status_t st;
		logic [63:0]      val;
	} plan_row_t;

	logic               clk        = 1'b0;
	logic               arst_n     = 1'b0;
	logic               cfg_we     = 1'b0;
	logic [7:0]         cfg_wdata  = '0;
	logic               in_valid   = 1'b0;
	logic               in_stall;
	logic               req_type   = tae_pkg::REQ_START;
	logic [31:0]        insn_word  = '0;
	logic signed [63:0] arg_first  = '0;
	logic signed [63:0] arg_second = '0;
	logic               out_valid;
	logic               out_stall  = 1'b0;
	logic [2:0]         status;
	logic signed [63:0] ret_value;

	// predictor state
	logic [63:0] gpr [tae_pkg::NUM_REGS];
	logic [7:0]  stk_bytes [tae_pkg::STACK_BYTES];
	logic [7:0]  n_exec;
	logic [7:0]  insn_lim;
	logic        run_active;

	exec_outcome_t pending_results[$];
	plan_row_t     plan[$];

	int  n_errors = 0;
	int  n_sent = 0;
	int  n_results = 0;
	int  n_limits = 1;
	int  seen_status [8];
	int  cyc = 0;
	int  burst_left = 0;
	bit  gap_free = 0;
	bit  wrap_up = 0;
	int  stall_mode = 0;
	int  stall_cnt = 0;

	tiny_a64_subset_executor uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.req_type  (req_type),
		.insn_word (insn_word),
		.arg_first (arg_first),
		.arg_second(arg_second),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.status    (status),
		.ret_value (ret_value)
	);

	always #5 clk = ~clk;

	function automatic exec_outcome_t step_executor(logic rt, logic [31:0] w,
		logic [63:0] a1, logic [63:0] a2);
		exec_outcome_t o;
		logic [15:0]   op;
		logic [4:0]    rd, rn, rm;
		logic [63:0]   imm, ea;
		logic [31:0]   word32;
		logic          counted;
		int            idx;
		o.st = tae_pkg::ST_RUN;
		o.val = '0;
		if (rt == tae_pkg::REQ_START) begin
			gpr[0] = a2;
			gpr[1] = a1;
			gpr[SP] = tae_pkg::STACK_TOP;
			n_exec = '0;
			run_active = 1'b1;
		end else if (!run_active) begin
			o.st = tae_pkg::ST_IDLE;
		end else begin
			op = w[31:16];
			rd = w[4:0];
			rn = w[9:5];
			rm = w[20:16];
			imm = 64'(w[21:10]);
			ea = gpr[rn] + (imm << 2);
			counted = 1'b1;
			case (op)
				tae_pkg::OP_LDR32: begin
					if (ea > tae_pkg::ADDR_MAX) begin
						o.st = tae_pkg::ST_BADADDR;
						counted = 1'b0;
					end else begin
						idx = int'(ea);
						word32 = {stk_bytes[idx + 3], stk_bytes[idx + 2],
							stk_bytes[idx + 1], stk_bytes[idx]};
						gpr[rd] = {{32{word32[31]}}, word32};
					end
				end
				tae_pkg::OP_STR32: begin
					if (ea > tae_pkg::ADDR_MAX) begin
						o.st = tae_pkg::ST_BADADDR;
						counted = 1'b0;
					end else begin
						idx = int'(ea);
						stk_bytes[idx]     = gpr[rd][7:0];
						stk_bytes[idx + 1] = gpr[rd][15:8];
						stk_bytes[idx + 2] = gpr[rd][23:16];
						stk_bytes[idx + 3] = gpr[rd][31:24];
					end
				end
				tae_pkg::OP_SUBI: gpr[rd] = gpr[rn] - imm;
				tae_pkg::OP_ADDR: gpr[rd] = gpr[rn] + gpr[rm];
				tae_pkg::OP_ADDI: gpr[rd] = gpr[rn] + imm;
				tae_pkg::OP_RET: begin
					o.st = tae_pkg::ST_RET;
					o.val = gpr[0];
					counted = 1'b0;
				end
				default: begin
					o.st = tae_pkg::ST_BADOP;
					counted = 1'b0;
				end
			endcase
			if (counted) begin
				n_exec = n_exec + 8'd1;
				if (n_exec >= insn_lim)
					o.st = tae_pkg::ST_LIMIT;
			end
			if (o.st != tae_pkg::ST_RUN)
				run_active = 1'b0;
		end
		return o;
	endfunction

	function automatic logic [31:0] insn(logic [15:0] op, int imm, int rn, int rd);
		return {op, 16'h0} | (32'(imm) << 10) | (32'(rn) << 5) | 32'(rd);
	endfunction

	function automatic logic [63:0] rand64();
		return {$urandom, $urandom};
	endfunction

	function automatic int pick_base();
		int k;
		k = $urandom_range(0, 9);
		if (k < 4)
			return SP;
		if (k < 7)
			return $urandom_range(0, 5);
		return $urandom_range(0, 31);
	endfunction

	function automatic logic [63:0] pick_arg();
		int k;
		k = $urandom_range(0, 19);
		if (k < 10)
			return 64'($urandom_range(0, 63));
		if (k < 14)
			return rand64();
		if (k < 17) begin
			case ($urandom_range(0, 3))
				0: return POS_MAX;
				1: return NEG_MIN;
				2: return ALL_ONES;
				default: return '0;
			endcase
		end
		return -64'($urandom_range(1, 64));
	endfunction

	function automatic logic [31:0] gen_insn(bit alu_only);
		int          k, rd, rn, imm;
		logic [15:0] near;
		k = alu_only ? $urandom_range(40, 84) : $urandom_range(0, 99);
		rd = $urandom_range(0, 31);
		rn = pick_base();
		imm = ($urandom_range(0, 4) != 0) ? $urandom_range(0, 3) : $urandom_range(0, 63);
		if (k < 20)
			return insn(tae_pkg::OP_LDR32, imm, rn, rd);
		if (k < 40)
			return insn(tae_pkg::OP_STR32, imm, rn, rd);
		imm = $urandom_range(0, 63);
		if (k < 55)
			return insn(tae_pkg::OP_ADDI, imm, rn, rd);
		if (k < 70)
			return insn(tae_pkg::OP_SUBI, imm, rn, rd);
		if (k < 85)
			return insn(tae_pkg::OP_ADDR, imm, rn, rd);  // bits 15:10 are don't-care here
		if (k < 92)
			return {tae_pkg::OP_RET, 16'($urandom)};
		if (k < 96)
			return $urandom;
		// one bit off a legal opcode
		case ($urandom_range(0, 5))
			0: near = tae_pkg::OP_LDR32;
			1: near = tae_pkg::OP_STR32;
			2: near = tae_pkg::OP_SUBI;
			3: near = tae_pkg::OP_ADDR;
			4: near = tae_pkg::OP_ADDI;
			default: near = tae_pkg::OP_RET;
		endcase
		return {near ^ (16'd1 << $urandom_range(0, 15)), 16'($urandom)};
	endfunction

	task automatic report_mismatch(string msg);
		$display("[%0t] mismatch: %s", $time, msg);
		n_errors++;
	endtask

	task automatic send(logic rt, logic [31:0] w, logic [63:0] a1, logic [63:0] a2,
		bit pin = 0, tae_pkg::status_t pst = tae_pkg::ST_RUN, logic [63:0] pval = '0);
		exec_outcome_t o;
		int            gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if ($urandom_range(0, 3) == 0)
				gap_free = !gap_free;
			gap = gap_free ? 0 : $urandom_range(1, 6);
			if (gap > 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		in_valid   <= 1'b1;
		req_type   <= rt;
		insn_word  <= w;
		arg_first  <= a1;
		arg_second <= a2;
		do @(posedge clk); while (in_stall !== 1'b0);
		burst_left--;
		n_sent++;
		o = step_executor(rt, w, a1, a2);
		if (pin) begin
			o.st = pst;
			o.val = pval;
		end
		pending_results.push_back(o);
	endtask

	task automatic wait_results();
		in_valid <= 1'b0;
		burst_left = 0;
		while (pending_results.size() != 0) @(posedge clk);
	endtask

	task automatic set_insn_limit(logic [7:0] v);
		wait_results();
		repeat (4) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		insn_lim = v;
		n_limits++;
	endtask

	task automatic run_program(int n, bit alu_only);
		send(tae_pkg::REQ_START, $urandom, pick_arg(), pick_arg());
		// pull the stack pointer down so loads and stores land inside the stack
		if (!alu_only && $urandom_range(0, 1) == 1)
			send(tae_pkg::REQ_EXEC, insn(tae_pkg::OP_SUBI, $urandom_range(4, 63), SP, SP),
				rand64(), rand64());
		repeat (n) send(tae_pkg::REQ_EXEC, gen_insn(alu_only), rand64(), rand64());
	endtask

	task automatic random_phase(int goal);
		int stop_at;
		int top;
		stop_at = n_sent + goal;
		while (n_sent < stop_at) begin
			top = (insn_lim > 20) ? 24 : int'(insn_lim) + 3;
			run_program($urandom_range(1, top), 0);
			if ($urandom_range(0, 9) == 0)
				wait_results();
		end
	endtask

	task automatic add_row(logic rt, logic [31:0] w, logic [63:0] a1, logic [63:0] a2,
		bit pin = 0, tae_pkg::status_t st = tae_pkg::ST_RUN, logic [63:0] val = '0);
		plan_row_t r;
		r.rt = rt;
		r.w = w;
		r.a1 = a1;
		r.a2 = a2;
		r.pin = pin;
		r.st = st;
		r.val = val;
		plan.push_back(r);
	endtask

	// receiver back-pressure: a randomly chosen mode, redrawn when stall_cnt runs out
	always @(posedge clk) begin
		cyc <= cyc + 1;
		if (stall_cnt == 0) begin
			stall_mode <= $urandom_range(0, 3);
			stall_cnt  <= $urandom_range(20, 80);
		end else begin
			stall_cnt <= stall_cnt - 1;
		end
		if (wrap_up)
			out_stall <= 1'b0;
		else case (stall_mode)
			0: out_stall <= 1'b0;
			1: out_stall <= ($urandom_range(0, 2) == 0);
			2: out_stall <= ($urandom_range(0, 3) != 0);
			default: out_stall <= ((cyc % 8) < 3);
		endcase
		if (cyc == MAX_CYCLES) begin
			$display("simulation failed");
			$finish;
		end
	end

	always @(posedge clk) begin
		exec_outcome_t e;
		if (arst_n && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (pending_results.size() == 0) begin
				report_mismatch($sformatf("result with nothing pending, status %0d", status));
			end else begin
				e = pending_results.pop_front();
				n_results++;
				seen_status[e.st]++;
				if (status !== e.st)
					report_mismatch($sformatf("status %0d, expected %0d", status, e.st));
				if (ret_value !== e.val)
					report_mismatch($sformatf("ret_value %h, expected %h", ret_value, e.val));
			end
		end
	end

	initial begin
		int phase_lim [5];
		foreach (gpr[i])
			gpr[i] = '0;
		foreach (stk_bytes[i])
			stk_bytes[i] = '0;
		foreach (seen_status[i])
			seen_status[i] = 0;
		n_exec = '0;
		run_active = 1'b0;
		insn_lim = tae_pkg::LIMIT_RESET;

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part, reset limit of 8
		add_row(tae_pkg::REQ_EXEC, insn(tae_pkg::OP_ADDI, 1, 0, 0), '0, '0,
			1, tae_pkg::ST_IDLE, '0);
		add_row(tae_pkg::REQ_START, '0, POS_MAX, NEG_MIN, 1, tae_pkg::ST_RUN, '0);
		add_row(tae_pkg::REQ_EXEC, insn(tae_pkg::OP_RET, 0, 0, 0), '0, '0,
			1, tae_pkg::ST_RET, NEG_MIN);
		add_row(tae_pkg::REQ_EXEC, insn(tae_pkg::OP_RET, 0, 0, 0), '0, '0,
			1, tae_pkg::ST_IDLE, '0);
		add_row(tae_pkg::REQ_START, ALL_ONES, ALL_ONES, POS_MAX, 1, tae_pkg::ST_RUN, '0);
		add_row(tae_pkg::REQ_EXEC, insn(tae_pkg::OP_ADDI, 63, 0, 0), '0, '0);   // wraps past max
		add_row(tae_pkg::REQ_EXEC, insn(tae_pkg::OP_SUBI, 63, 1, 1), '0, '0);
		add_row(tae_pkg::REQ_EXEC, insn(tae_pkg::OP_ADDR, 0, 0, 2), '0, '0);
		add_row(tae_pkg::REQ_EXEC, 32'hFFFF_FFFF, ALL_ONES, ALL_ONES,
			1, tae_pkg::ST_BADOP, '0);
		add_row(tae_pkg::REQ_START, '0, 64'h1234_5678_9ABC_DEF0, '0, 1, tae_pkg::ST_RUN, '0);
		// stack top itself is out of range for a 4-byte access
		add_row(tae_pkg::REQ_EXEC, insn(tae_pkg::OP_STR32, 0, SP, 0), '0, '0,
			1, tae_pkg::ST_BADADDR, '0);
		add_row(tae_pkg::REQ_START, '0, 64'h1234_5678_9ABC_DEF0, '0, 1, tae_pkg::ST_RUN, '0);
		add_row(tae_pkg::REQ_EXEC, insn(tae_pkg::OP_SUBI, 4, SP, SP), '0, '0);
		add_row(tae_pkg::REQ_EXEC, insn(tae_pkg::OP_STR32, 0, SP, 1), '0, '0);  // last legal word
		// negative, sign-extended
		add_row(tae_pkg::REQ_EXEC, insn(tae_pkg::OP_LDR32, 0, SP, 3), '0, '0);
		add_row(tae_pkg::REQ_EXEC, insn(tae_pkg::OP_ADDI, 1, SP, 5), '0, '0);
		add_row(tae_pkg::REQ_EXEC, insn(tae_pkg::OP_ADDR, 0, 3, 8), '0, '0);
		add_row(tae_pkg::REQ_EXEC, insn(tae_pkg::OP_SUBI, 1, 8, 9), '0, '0);
		add_row(tae_pkg::REQ_EXEC, insn(tae_pkg::OP_ADDI, 0, 10, 10), '0, '0);
		add_row(tae_pkg::REQ_EXEC, insn(tae_pkg::OP_ADDI, 0, 11, 11), '0, '0,
			1, tae_pkg::ST_LIMIT, '0);
		add_row(tae_pkg::REQ_START, '0, ALL_ONES, 64'h8000_0000, 1, tae_pkg::ST_RUN, '0);
		add_row(tae_pkg::REQ_EXEC, insn(tae_pkg::OP_LDR32, 0, 5, 6), '0, '0,
			1, tae_pkg::ST_BADADDR, '0);
		add_row(tae_pkg::REQ_START, '0, ALL_ONES, 64'h8000_0000, 1, tae_pkg::ST_RUN, '0);
		// base of -1 plus 4 wraps to byte 3
		add_row(tae_pkg::REQ_EXEC, insn(tae_pkg::OP_STR32, 1, 1, 0), '0, '0);
		add_row(tae_pkg::REQ_EXEC, insn(tae_pkg::OP_LDR32, 1, 1, 7), '0, '0);
		add_row(tae_pkg::REQ_EXEC, {tae_pkg::OP_RET, 16'hFFFF}, '0, '0,
			1, tae_pkg::ST_RET, 64'h8000_0000);
		foreach (plan[i])
			send(plan[i].rt, plan[i].w, plan[i].a1, plan[i].a2,
				plan[i].pin, plan[i].st, plan[i].val);

		random_phase(25);

		phase_lim[0] = 1;
		phase_lim[1] = 255;
		phase_lim[2] = 3;
		phase_lim[3] = $urandom_range(2, 254);
		phase_lim[4] = 16;
		foreach (phase_lim[p]) begin
			set_insn_limit(8'(phase_lim[p]));
			if (phase_lim[p] == 255)
				run_program(256, 1);  // runs all the way to the top limit
			random_phase(25);
		end

		wait_results();
		wrap_up = 1;
		repeat (8) @(posedge clk);

		$display("covered %0d transactions, %0d results checked, %0d limit settings",
			n_sent, n_results, n_limits);
		$display("run/ret/badop/badaddr/limit/idle: %0d/%0d/%0d/%0d/%0d/%0d",
			seen_status[tae_pkg::ST_RUN], seen_status[tae_pkg::ST_RET],
			seen_status[tae_pkg::ST_BADOP], seen_status[tae_pkg::ST_BADADDR],
			seen_status[tae_pkg::ST_LIMIT], seen_status[tae_pkg::ST_IDLE]);
		if (n_errors == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

endmodule
